// ===== hdl/tcw_pkg.sv =====
// Shared constants for the text console writer.
// No dependencies; used by text_console_writer_core.
package tcw_pkg;

   localparam int unsigned COLS_DEFAULT = 80;
   localparam int unsigned ROWS_DEFAULT = 25;

   localparam logic [7:0] DFLT_ATTR_RESET = 8'd15;
   localparam logic [7:0] NEWLINE_CODE    = 8'd10;

   localparam logic ACT_PUT  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned ATTR_W = 8;
   localparam int unsigned CELL_W = CHAR_W + ATTR_W;

endpackage

// ===== hdl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/text_console_writer_core.sv =====
// Text console writer: cell store in a RAM, cursor, scroll and clear sequencer.
// Depends on tcw_pkg and tcw_ram.
//
//  channel | ports                      | handshake
//  --------+----------------------------+-------------------------------------
//  request | start, busy, req_*         | item taken when start && !busy
//  result  | rsp_valid, rsp_*           | one-cycle strobe, no backpressure
//  config  | csr_valid, csr_ready, csr_ | write when csr_valid && csr_ready
//
// A put is answered from idle; a read passes through the registered RAM read and
// the read state. The result strobes the cycle after the item finishes. A put that
// scrolls holds busy while the single RAM write port copies one cell per cycle and
// then clears the last row. After reset the store is cleared one cell per cycle,
// with busy high. Results cannot be stalled.
module text_console_writer_core #(
   parameter int unsigned COLS = tcw_pkg::COLS_DEFAULT,
   parameter int unsigned ROWS = tcw_pkg::ROWS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_action,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_attribute,
   input  logic       req_use_cursor,
   input  logic [6:0] req_column,
   input  logic [4:0] req_row,
   output logic       rsp_valid,
   output logic [6:0] rsp_cursor_column,
   output logic [4:0] rsp_cursor_row,
   output logic       rsp_scrolled,
   output logic [7:0] rsp_cell_char,
   output logic [7:0] rsp_cell_attribute,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_wdata
);

   localparam int unsigned CW    = $clog2(COLS);
   localparam int unsigned RW    = $clog2(ROWS);
   localparam int unsigned DEPTH = ROWS * (2 ** CW);
   localparam int unsigned AW    = $clog2(DEPTH);

   localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
   localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
   localparam logic [RW-1:0] ROW_PREV = RW'(ROWS - 2);

   localparam logic [2:0] ST_CLEAR      = 3'd0;
   localparam logic [2:0] ST_IDLE       = 3'd1;
   localparam logic [2:0] ST_READ       = 3'd2;
   localparam logic [2:0] ST_SCROLL     = 3'd3;
   localparam logic [2:0] ST_SCROLL_CLR = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [CW-1:0] ctr_col_ff, ctr_col_in;
   logic [RW-1:0] ctr_row_ff, ctr_row_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]    dflt_attr_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_scrolled_ff, rsp_scrolled_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic [7:0]    rsp_attr_ff, rsp_attr_in;

   logic                      accept;
   logic [CW-1:0]             clamp_col;
   logic [RW-1:0]             clamp_row;
   logic [CW-1:0]             pos_col;
   logic [RW-1:0]             pos_row;
   logic                      is_newline;
   logic                      wrap;
   logic                      do_scroll;
   logic [7:0]                attr_sel;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [tcw_pkg::CELL_W-1:0] wr_data;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic [tcw_pkg::CELL_W-1:0] rd_data;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Saturate the requested cell to the screen.
   assign clamp_col = ({1'b0, req_column} > 8'(COLS - 1)) ? COL_LAST : CW'(req_column);
   assign clamp_row = (7'(req_row) > 7'(ROWS - 1)) ? ROW_LAST : RW'(req_row);

   assign pos_col    = req_use_cursor ? cur_col_ff : clamp_col;
   assign pos_row    = req_use_cursor ? cur_row_ff : clamp_row;
   assign is_newline = (req_char_code == tcw_pkg::NEWLINE_CODE);
   assign wrap       = is_newline || (pos_col == COL_LAST);
   assign do_scroll  = wrap && (pos_row == ROW_LAST);
   assign attr_sel   = (req_attribute == 8'd0) ? dflt_attr_ff : req_attribute;

   // RAM write port: a pending scroll copy wins over everything else.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {ctr_row_ff, ctr_col_ff};
      wr_data = '0;
      if (wr_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = rd_data;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               wr_en = 1'b1;
            end
            ST_IDLE: begin
               wr_en   = accept && (req_action == tcw_pkg::ACT_PUT) && !is_newline;
               wr_addr = {pos_row, pos_col};
               wr_data = {attr_sel, req_char_code};
            end
            ST_SCROLL_CLR: begin
               wr_en   = 1'b1;
               wr_addr = {ROW_LAST, ctr_col_ff};
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = {clamp_row, clamp_col};
      if (state_ff == ST_SCROLL) begin
         rd_en   = 1'b1;
         rd_addr = {ctr_row_ff + RW'(1), ctr_col_ff};
      end else if (accept && (req_action == tcw_pkg::ACT_READ)) begin
         rd_en = 1'b1;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      ctr_col_in      = ctr_col_ff;
      ctr_row_in      = ctr_row_ff;
      wr_pend_in      = 1'b0;
      pend_addr_in    = pend_addr_ff;
      rsp_valid_in    = 1'b0;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_attr_in     = rsp_attr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ctr_col_in = (ctr_col_ff == COL_LAST) ? '0 : ctr_col_ff + CW'(1);
            if (ctr_col_ff == COL_LAST) begin
               ctr_row_in = ctr_row_ff + RW'(1);
               if (ctr_row_ff == ROW_LAST) begin
                  ctr_row_in = '0;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_action == tcw_pkg::ACT_READ) begin
                  state_in = ST_READ;
               end else begin
                  rsp_char_in     = '0;
                  rsp_attr_in     = '0;
                  rsp_scrolled_in = do_scroll;
                  cur_col_in      = wrap ? '0 : pos_col + CW'(1);
                  cur_row_in      = wrap && !do_scroll ? pos_row + RW'(1) : pos_row;
                  if (do_scroll) begin
                     ctr_col_in = '0;
                     ctr_row_in = '0;
                     state_in   = ST_SCROLL;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            rsp_valid_in    = 1'b1;
            rsp_scrolled_in = 1'b0;
            rsp_char_in     = rd_data[tcw_pkg::CHAR_W-1:0];
            rsp_attr_in     = rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            state_in        = ST_IDLE;
         end
         ST_SCROLL: begin
            // Copy row r+1 into row r; the write lands in the cycle after the read.
            wr_pend_in   = 1'b1;
            pend_addr_in = {ctr_row_ff, ctr_col_ff};
            ctr_col_in   = (ctr_col_ff == COL_LAST) ? '0 : ctr_col_ff + CW'(1);
            if (ctr_col_ff == COL_LAST) begin
               ctr_row_in = ctr_row_ff + RW'(1);
               if (ctr_row_ff == ROW_PREV) begin
                  ctr_row_in = '0;
                  state_in   = ST_SCROLL_CLR;
               end
            end
         end
         ST_SCROLL_CLR: begin
            // Hold the clear counter while the last copy drains.
            if (!wr_pend_ff) begin
               ctr_col_in = (ctr_col_ff == COL_LAST) ? '0 : ctr_col_ff + CW'(1);
               if (ctr_col_ff == COL_LAST) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         ctr_col_ff   <= '0;
         ctr_row_ff   <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dflt_attr_ff <= tcw_pkg::DFLT_ATTR_RESET;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         ctr_col_ff   <= ctr_col_in;
         ctr_row_ff   <= ctr_row_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            dflt_attr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff    <= pend_addr_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_attr_ff     <= rsp_attr_in;
   end

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_column  = 7'(cur_col_ff);
   assign rsp_cursor_row     = 5'(cur_row_ff);
   assign rsp_scrolled       = rsp_scrolled_ff;
   assign rsp_cell_char      = rsp_char_ff;
   assign rsp_cell_attribute = rsp_attr_ff;

`ifndef SYNTHESIS
   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe outside idle");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || busy))
      else $error("accepted item neither answered nor in progress");

   a_pend_in_scroll: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> ((state_ff == ST_SCROLL) || (state_ff == ST_SCROLL_CLR)))
      else $error("scroll copy pending outside scroll");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_scrolled_ff) |-> ((cur_row_ff == ROW_LAST) && (cur_col_ff == '0)))
      else $error("scroll left cursor off the last row start");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cur_col_ff <= COL_LAST) && (cur_row_ff <= ROW_LAST))
      else $error("cursor outside screen");
`endif

endmodule
